// ===== rtl/ucb_pkg.sv =====
// shared types and constants for the ucb arm selector
// no dependencies; used by every module of the block
package ucb_pkg;

  localparam int MEAN_W  = 17;
  localparam int CNT_W   = 32;
  localparam int WALK_W  = 16;
  localparam int STEP_W  = 8;
  localparam int SCORE_W = 34;
  localparam int LN_W    = 21;
  localparam int DIV_NW  = 36;
  localparam int DIV_DW  = 32;
  localparam int SQ_VW   = 38;
  localparam int SQ_RW   = 20;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 16;

  localparam logic [MEAN_W-1:0] MEAN_MAX  = 17'h1FFFF;
  localparam logic [MEAN_W-1:0] REWARD_ONE = 17'h10000;
  localparam logic [WALK_W-1:0] WALKS_RST = 16'd100;
  localparam logic [STEP_W-1:0] STEPS_RST = 8'd1;
  localparam logic [31:0]       LN2_Q32   = 32'hB17217F8;

  localparam logic [CFG_IW-1:0] CFG_UCB_CONST   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ADJUST      = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_NUM_ARMS    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_INIT_WALKS  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_INIT_STEPS  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_WALKS_BOUND = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_STEPS_BOUND = 3'd6;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  count;
    logic [WALK_W-1:0] walks;
    logic [STEP_W-1:0] steps;
  } entry_t;

  localparam entry_t ENTRY_RST = '{mean: '0, count: '0, walks: WALKS_RST, steps: STEPS_RST};

  typedef enum logic [4:0] {
    ST_IDLE, ST_LN_WAIT, ST_SCAN_RD, ST_SCAN_EVAL, ST_SCORE_DIV, ST_SCORE_SQ,
    ST_SCORE_CMP, ST_CHOOSE, ST_MOD_WAIT, ST_PICK, ST_VL_RD, ST_VL_EVAL,
    ST_VL_DIV, ST_UP_RD, ST_UP_EVAL, ST_UP_RWD, ST_UP_CNT, ST_UP_DIV, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    LN_IDLE, LN_NORM, LN_SQR, LN_FIX, LN_SCALE, LN_DONE
  } ln_state_t;

endpackage

// ===== rtl/ucb_arm_mem.sv =====
// per-arm state table: mean, pull count, walk count, step limit
// registered read; valid bits make unwritten entries read as reset values
// depends on ucb_pkg
module ucb_arm_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output ucb_pkg::entry_t     rd_data,
  input  logic                we,
  input  logic [AW-1:0]       wr_addr,
  input  ucb_pkg::entry_t     wr_data
);

  ucb_pkg::entry_t   mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  ucb_pkg::entry_t   mem_q_r;
  logic              vld_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : ucb_pkg::ENTRY_RST;

endmodule

// ===== rtl/ucb_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on ucb_pkg for operand widths
module ucb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ucb_pkg::DIV_NW-1:0] num,
  input  logic [ucb_pkg::DIV_DW-1:0] den,
  output logic                       done,
  output logic [ucb_pkg::DIV_NW-1:0] quo,
  output logic [ucb_pkg::DIV_DW-1:0] rem
);

  localparam int NW = ucb_pkg::DIV_NW;
  localparam int DW = ucb_pkg::DIV_DW;
  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [KW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == KW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/ucb_sqrt.sv =====
// integer square root, one result bit per cycle
// depends on ucb_pkg for operand widths
module ucb_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ucb_pkg::SQ_VW-1:0] v,
  output logic                      done,
  output logic [ucb_pkg::SQ_RW-1:0] root
);

  localparam int IW   = ucb_pkg::SQ_VW + 2;
  localparam int ITER = IW / 2;
  localparam int KW   = $clog2(ITER + 1);

  logic [IW-1:0] v_r;
  logic [IW-1:0] r_r;
  logic [IW-1:0] bit_r;
  logic [KW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [IW-1:0] sum;

  assign sum = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= IW'(v);
      r_r   <= '0;
      bit_r <= IW'(1) << ucb_pkg::SQ_VW;
    end else if (busy_r) begin
      if (v_r >= sum) begin
        v_r <= v_r - sum;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == KW'(ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[ucb_pkg::SQ_RW-1:0];

endmodule

// ===== rtl/ucb_ln.sv =====
// natural log in q5.16: leading-one search, 16 squaring steps for log2, scale by ln2
// depends on ucb_pkg
module ucb_ln (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [31:0]              x,
  output logic                     done,
  output logic [ucb_pkg::LN_W-1:0] res
);

  ucb_pkg::ln_state_t state_r, state_nxt;

  logic [31:0]              y_r;
  logic [4:0]               k_r;
  logic [3:0]               it_r;
  logic [63:0]              sq_r;
  logic [ucb_pkg::LN_W-1:0] lg_r;
  logic [52:0]              prod_r;
  logic [31:0]              t;

  assign t = sq_r[61:30];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ucb_pkg::LN_IDLE:  if (start) begin
        state_nxt = (x == '0) ? ucb_pkg::LN_DONE : ucb_pkg::LN_NORM;
      end
      ucb_pkg::LN_NORM:  if (y_r[31]) begin
        state_nxt = ucb_pkg::LN_SQR;
      end
      ucb_pkg::LN_SQR:   state_nxt = ucb_pkg::LN_FIX;
      ucb_pkg::LN_FIX:   state_nxt = (it_r == 4'd15) ? ucb_pkg::LN_SCALE : ucb_pkg::LN_SQR;
      ucb_pkg::LN_SCALE: state_nxt = ucb_pkg::LN_DONE;
      ucb_pkg::LN_DONE:  state_nxt = ucb_pkg::LN_IDLE;
      default:           state_nxt = ucb_pkg::LN_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == ucb_pkg::LN_DONE);
    res  = prod_r[52:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ucb_pkg::LN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ucb_pkg::LN_IDLE: if (start) begin
        // result is held until the next start
        y_r    <= x;
        k_r    <= 5'd31;
        prod_r <= '0;
      end
      ucb_pkg::LN_NORM: begin
        if (y_r[31]) begin
          // align to q2.30 in [1, 2)
          y_r  <= y_r >> 1;
          lg_r <= {k_r, 16'b0};
          it_r <= '0;
        end else begin
          y_r <= y_r << 1;
          k_r <= k_r - 1'b1;
        end
      end
      ucb_pkg::LN_SQR: sq_r <= y_r * y_r;
      ucb_pkg::LN_FIX: begin
        if (t[31]) begin
          y_r <= t >> 1;
          lg_r[{1'b0, 4'd15 - it_r}] <= 1'b1;
        end else begin
          y_r <= t;
        end
        it_r <= it_r + 1'b1;
      end
      ucb_pkg::LN_SCALE: prod_r <= 53'(lg_r) * 53'(ucb_pkg::LN2_Q32);
      default: ;
    endcase
  end

endmodule

// ===== rtl/ucb_bandit_arm_selector.sv =====
// ucb1 arm selector: sequencer over the per-arm table, shared divider, ln and sqrt units
// depends on ucb_pkg, ucb_arm_mem, ucb_div, ucb_ln, ucb_sqrt
//
// channel  | handshake                 | word
// ---------+---------------------------+-------------------------------------------
// request  | start, busy               | in_req_type in_arm in_heuristic in_bound
//          |                           | in_rand_value
// result   | out_valid (1-cycle strobe)| out_chosen_arm out_was_untried
//          |                           | out_walk_setting out_step_setting
// config   | cfg_valid, cfg_ready      | cfg_index cfg_data
//
// a select computes ln(total), then for each tried arm a divide, a sqrt, a multiply and a
// compare, then a modulo, a walk of the candidate mask and a divide for the virtual loss;
// a negative c (dovetail mode) skips the ln and the per-arm divide and sqrt
// an update of an arm in use runs two divides back to back, the first only for a nonzero bound
// the table needs no clearing pass: valid bits are cleared by reset
// results cannot be stalled; busy stays high until the result strobe has gone
module ucb_bandit_arm_selector #(
  parameter int MAX_ARMS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [3:0]                  in_arm,
  input  logic [19:0]                 in_heuristic,
  input  logic [19:0]                 in_bound,
  input  logic [31:0]                 in_rand_value,
  output logic                        out_valid,
  output logic [3:0]                  out_chosen_arm,
  output logic                        out_was_untried,
  output logic [15:0]                 out_walk_setting,
  output logic [7:0]                  out_step_setting,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ucb_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ucb_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int AW = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
  localparam int CW = $clog2(MAX_ARMS + 1);

  ucb_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic signed [15:0] ucb_const_r;
  logic               adjust_r;
  logic [4:0]         num_arms_r;
  logic [15:0]        init_walks_r;
  logic [7:0]         init_steps_r;
  logic [15:0]        walks_bound_r;
  logic [7:0]         steps_bound_r;

  // latched request word
  logic [3:0]         arm_r;
  logic [19:0]        h_r;
  logic [19:0]        bnd_r;
  logic [31:0]        rnd_r;

  // scan bookkeeping
  logic [31:0]                        total_r;
  logic [AW-1:0]                      idx_r;
  logic [AW-1:0]                      pick_r;
  logic [MAX_ARMS-1:0]                untried_r;
  logic [MAX_ARMS-1:0]                tied_r;
  logic [CW-1:0]                      nu_r;
  logic [CW-1:0]                      nt_r;
  logic [CW-1:0]                      seen_r;
  logic [CW-1:0]                      rank_r;
  logic                               unused_r;
  logic signed [ucb_pkg::SCORE_W-1:0] best_r;
  logic [34:0]                        prod_r;
  logic [ucb_pkg::MEAN_W-1:0]         reward_r;
  ucb_pkg::entry_t                    wrk_r;

  // unit connections
  ucb_pkg::entry_t               ent;
  ucb_pkg::entry_t               wr_ent;
  logic                          mem_rd_en;
  logic [AW-1:0]                 mem_rd_addr;
  logic                          mem_we;
  logic [AW-1:0]                 mem_wr_addr;
  logic                          div_start;
  logic [ucb_pkg::DIV_NW-1:0]    div_num;
  logic [ucb_pkg::DIV_DW-1:0]    div_den;
  logic                          div_done;
  logic [ucb_pkg::DIV_NW-1:0]    div_quo;
  logic [ucb_pkg::DIV_DW-1:0]    div_rem;
  logic                          ln_start;
  logic                          ln_done;
  logic [ucb_pkg::LN_W-1:0]      ln_res;
  logic                          sq_start;
  logic                          sq_done;
  logic [ucb_pkg::SQ_RW-1:0]     sq_root;

  // derived values
  logic                               accept;
  logic                               c_neg;
  logic [CW-1:0]                      use_w;
  logic                               scan_last;
  logic [AW-1:0]                      arm_idx;
  logic [CW-1:0]                      n_sel;
  logic                               mask_bit;
  logic signed [ucb_pkg::SCORE_W-1:0] cand;
  logic [ucb_pkg::CNT_W-1:0]          cnt_inc;
  logic [16:0]                        w2;
  logic [8:0]                         st1;
  logic [15:0]                        walks_adj;
  logic [7:0]                         steps_adj;
  logic [19:0]                        hc;
  logic [17:0]                        msum;
  logic [ucb_pkg::MEAN_W-1:0]         mean_up;

  assign accept    = start && !busy;
  assign c_neg     = ucb_const_r[15];
  assign cfg_ready = 1'b1;

  // arms in use: zero counts as one, clamp to the table depth
  always_comb begin
    if (num_arms_r == '0) begin
      use_w = CW'(1);
    end else if (32'(num_arms_r) > 32'(MAX_ARMS)) begin
      use_w = CW'(MAX_ARMS);
    end else begin
      use_w = CW'(num_arms_r);
    end
  end

  assign scan_last = (32'(idx_r) == 32'(use_w) - 32'd1);
  assign arm_idx   = AW'(arm_r);
  assign n_sel     = (nu_r != '0) ? nu_r : nt_r;
  assign mask_bit  = unused_r ? untried_r[idx_r] : tied_r[idx_r];

  // candidate score: dovetail in the eval state, ucb term in the compare state
  always_comb begin
    if (state_r == ucb_pkg::ST_SCORE_CMP) begin
      cand = $signed({17'b0, ent.mean}) + $signed({7'b0, prod_r[34:8]});
    end else begin
      cand = $signed({2'b0, total_r}) - $signed({2'b0, ent.count});
    end
  end

  // virtual loss and online adjustment
  assign cnt_inc   = (ent.count == '1) ? ent.count : ent.count + 1'b1;
  assign w2        = {ent.walks, 1'b0};
  assign st1       = {1'b0, ent.steps} + 9'd1;
  assign walks_adj = (w2 < {1'b0, walks_bound_r}) ? w2[15:0] : walks_bound_r;
  assign steps_adj = (st1 < {1'b0, steps_bound_r}) ? st1[7:0] : steps_bound_r;

  // reward path
  assign hc      = (h_r < bnd_r) ? h_r : bnd_r;
  assign msum    = {1'b0, wrk_r.mean} + {1'b0, div_quo[16:0]};
  assign mean_up = (msum > {1'b0, ucb_pkg::MEAN_MAX}) ? ucb_pkg::MEAN_MAX : msum[16:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ucb_pkg::ST_IDLE: if (accept) begin
        if (in_req_type) begin
          state_nxt = (32'(in_arm) >= 32'(use_w)) ? ucb_pkg::ST_OUT : ucb_pkg::ST_UP_RD;
        end else begin
          state_nxt = c_neg ? ucb_pkg::ST_SCAN_RD : ucb_pkg::ST_LN_WAIT;
        end
      end
      ucb_pkg::ST_LN_WAIT: if (ln_done) begin
        state_nxt = ucb_pkg::ST_SCAN_RD;
      end
      ucb_pkg::ST_SCAN_RD: state_nxt = ucb_pkg::ST_SCAN_EVAL;
      ucb_pkg::ST_SCAN_EVAL: begin
        if (ent.count == '0 || c_neg) begin
          state_nxt = scan_last ? ucb_pkg::ST_CHOOSE : ucb_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = ucb_pkg::ST_SCORE_DIV;
        end
      end
      ucb_pkg::ST_SCORE_DIV: if (div_done) begin
        state_nxt = ucb_pkg::ST_SCORE_SQ;
      end
      ucb_pkg::ST_SCORE_SQ: if (sq_done) begin
        state_nxt = ucb_pkg::ST_SCORE_CMP;
      end
      ucb_pkg::ST_SCORE_CMP: state_nxt = scan_last ? ucb_pkg::ST_CHOOSE : ucb_pkg::ST_SCAN_RD;
      ucb_pkg::ST_CHOOSE:
        state_nxt = (n_sel == '0) ? ucb_pkg::ST_VL_RD : ucb_pkg::ST_MOD_WAIT;
      ucb_pkg::ST_MOD_WAIT: if (div_done) begin
        state_nxt = ucb_pkg::ST_PICK;
      end
      ucb_pkg::ST_PICK: if (mask_bit && seen_r == rank_r) begin
        state_nxt = ucb_pkg::ST_VL_RD;
      end
      ucb_pkg::ST_VL_RD:   state_nxt = ucb_pkg::ST_VL_EVAL;
      ucb_pkg::ST_VL_EVAL: state_nxt = ucb_pkg::ST_VL_DIV;
      ucb_pkg::ST_VL_DIV: if (div_done) begin
        state_nxt = ucb_pkg::ST_OUT;
      end
      ucb_pkg::ST_UP_RD: state_nxt = ucb_pkg::ST_UP_EVAL;
      ucb_pkg::ST_UP_EVAL:
        state_nxt = (bnd_r != '0) ? ucb_pkg::ST_UP_RWD : ucb_pkg::ST_UP_CNT;
      ucb_pkg::ST_UP_RWD: if (div_done) begin
        state_nxt = ucb_pkg::ST_UP_CNT;
      end
      ucb_pkg::ST_UP_CNT: state_nxt = ucb_pkg::ST_UP_DIV;
      ucb_pkg::ST_UP_DIV: if (div_done) begin
        state_nxt = ucb_pkg::ST_OUT;
      end
      ucb_pkg::ST_OUT: state_nxt = ucb_pkg::ST_IDLE;
      default: state_nxt = ucb_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    busy        = (state_r != ucb_pkg::ST_IDLE);
    out_valid   = (state_r == ucb_pkg::ST_OUT);
    ln_start    = (state_r == ucb_pkg::ST_IDLE) && accept && !in_req_type && !c_neg;
    sq_start    = (state_r == ucb_pkg::ST_SCORE_DIV) && div_done;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r;
    mem_we      = 1'b0;
    mem_wr_addr = pick_r;
    wr_ent      = wrk_r;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    case (state_r)
      ucb_pkg::ST_SCAN_RD: mem_rd_en = 1'b1;
      ucb_pkg::ST_SCAN_EVAL: begin
        div_start = (ent.count != '0) && !c_neg;
        div_num   = ucb_pkg::DIV_NW'({ln_res, 1'b0});
        div_den   = ent.count;
      end
      ucb_pkg::ST_CHOOSE: begin
        div_start = (n_sel != '0);
        div_num   = ucb_pkg::DIV_NW'(rnd_r);
        div_den   = ucb_pkg::DIV_DW'(n_sel);
      end
      ucb_pkg::ST_VL_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = pick_r;
      end
      ucb_pkg::ST_VL_EVAL: begin
        div_start = 1'b1;
        div_num   = ucb_pkg::DIV_NW'(ent.mean);
        div_den   = cnt_inc;
      end
      ucb_pkg::ST_VL_DIV: begin
        mem_we      = div_done;
        wr_ent.mean = wrk_r.mean - div_quo[16:0];
      end
      ucb_pkg::ST_UP_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = arm_idx;
      end
      ucb_pkg::ST_UP_EVAL: begin
        div_start = (bnd_r != '0);
        div_num   = {bnd_r - hc, 16'b0};
        div_den   = ucb_pkg::DIV_DW'(bnd_r);
      end
      ucb_pkg::ST_UP_CNT: begin
        div_start = 1'b1;
        div_num   = ucb_pkg::DIV_NW'(reward_r);
        div_den   = (wrk_r.count == '0) ? ucb_pkg::DIV_DW'(1) : wrk_r.count;
      end
      ucb_pkg::ST_UP_DIV: begin
        mem_we      = div_done;
        mem_wr_addr = arm_idx;
        wr_ent.mean = mean_up;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ucb_pkg::ST_IDLE;
      ucb_const_r   <= 16'sd256;
      adjust_r      <= 1'b0;
      num_arms_r    <= 5'd16;
      init_walks_r  <= 16'd100;
      init_steps_r  <= 8'd1;
      walks_bound_r <= 16'd2000;
      steps_bound_r <= 8'd7;
      total_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ucb_pkg::CFG_UCB_CONST:   ucb_const_r   <= $signed(cfg_data);
          ucb_pkg::CFG_ADJUST:      adjust_r      <= cfg_data[0];
          ucb_pkg::CFG_NUM_ARMS:    num_arms_r    <= cfg_data[4:0];
          ucb_pkg::CFG_INIT_WALKS:  init_walks_r  <= cfg_data;
          ucb_pkg::CFG_INIT_STEPS:  init_steps_r  <= cfg_data[7:0];
          ucb_pkg::CFG_WALKS_BOUND: walks_bound_r <= cfg_data;
          ucb_pkg::CFG_STEPS_BOUND: steps_bound_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      // saturating pull total
      if (state_r == ucb_pkg::ST_VL_DIV && div_done && total_r != '1) begin
        total_r <= total_r + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ucb_pkg::ST_IDLE: if (accept) begin
        arm_r     <= in_arm;
        h_r       <= in_heuristic;
        bnd_r     <= in_bound;
        rnd_r     <= in_rand_value;
        idx_r     <= '0;
        nu_r      <= '0;
        nt_r      <= '0;
        untried_r <= '0;
        tied_r    <= '0;
        best_r    <= '1;
        // an update of an arm out of range reports its arm with zero settings straight away
        out_chosen_arm   <= in_arm;
        out_was_untried  <= 1'b0;
        out_walk_setting <= '0;
        out_step_setting <= '0;
      end
      ucb_pkg::ST_SCAN_EVAL: begin
        if (ent.count == '0) begin
          untried_r[idx_r] <= 1'b1;
          nu_r             <= nu_r + 1'b1;
        end else if (c_neg) begin
          if (cand > best_r) begin
            best_r        <= cand;
            tied_r        <= '0;
            tied_r[idx_r] <= 1'b1;
            nt_r          <= CW'(1);
          end else if (cand == best_r) begin
            tied_r[idx_r] <= 1'b1;
            nt_r          <= nt_r + 1'b1;
          end
        end
        if ((ent.count == '0 || c_neg) && !scan_last) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ucb_pkg::ST_SCORE_SQ: if (sq_done) begin
        // c is known non-negative here
        prod_r <= 35'(ucb_const_r[14:0]) * 35'(sq_root);
      end
      ucb_pkg::ST_SCORE_CMP: begin
        if (cand > best_r) begin
          best_r        <= cand;
          tied_r        <= '0;
          tied_r[idx_r] <= 1'b1;
          nt_r          <= CW'(1);
        end else if (cand == best_r) begin
          tied_r[idx_r] <= 1'b1;
          nt_r          <= nt_r + 1'b1;
        end
        if (!scan_last) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ucb_pkg::ST_CHOOSE: begin
        unused_r <= (nu_r != '0);
        pick_r   <= '0;
      end
      ucb_pkg::ST_MOD_WAIT: if (div_done) begin
        rank_r <= div_rem[CW-1:0];
        idx_r  <= '0;
        seen_r <= '0;
      end
      ucb_pkg::ST_PICK: begin
        if (mask_bit && seen_r == rank_r) begin
          pick_r <= idx_r;
        end else begin
          seen_r <= seen_r + CW'(mask_bit);
          idx_r  <= idx_r + 1'b1;
        end
      end
      ucb_pkg::ST_VL_EVAL: begin
        wrk_r.mean  <= ent.mean;
        wrk_r.count <= cnt_inc;
        if (adjust_r && unused_r) begin
          wrk_r.walks <= init_walks_r;
          wrk_r.steps <= init_steps_r;
        end else if (adjust_r) begin
          wrk_r.walks <= walks_adj;
          wrk_r.steps <= steps_adj;
        end else begin
          wrk_r.walks <= ent.walks;
          wrk_r.steps <= ent.steps;
        end
      end
      ucb_pkg::ST_VL_DIV: if (div_done) begin
        out_chosen_arm   <= 4'(pick_r);
        out_was_untried  <= unused_r;
        out_walk_setting <= wrk_r.walks;
        out_step_setting <= wrk_r.steps;
      end
      ucb_pkg::ST_UP_EVAL: begin
        wrk_r    <= ent;
        reward_r <= ucb_pkg::REWARD_ONE;
      end
      ucb_pkg::ST_UP_RWD: if (div_done) begin
        reward_r <= div_quo[16:0];
      end
      ucb_pkg::ST_UP_DIV: if (div_done) begin
        out_chosen_arm   <= arm_r;
        out_was_untried  <= 1'b0;
        out_walk_setting <= wrk_r.walks;
        out_step_setting <= wrk_r.steps;
      end
      default: ;
    endcase
  end

  ucb_arm_mem #(.DEPTH(MAX_ARMS), .AW(AW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (ent),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (wr_ent)
  );

  ucb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  ucb_ln u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ln_start),
    .x     (total_r),
    .done  (ln_done),
    .res   (ln_res)
  );

  ucb_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .v     ({div_quo[21:0], 16'b0}),
    .done  (sq_done),
    .root  (sq_root)
  );

  // a table write is always followed by the result strobe
  a_write_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> out_valid)
    else $error("table write not followed by result");

  // the result strobe is never asserted back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // an accepted request holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // the log unit only finishes while the sequencer waits for it
  a_ln_waited: assert property (@(posedge clk) disable iff (!rst_n)
    ln_done |-> (state_r == ucb_pkg::ST_LN_WAIT))
    else $error("log result arrived outside its wait state");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the ucb arm selector: queued request driver, result monitor
// and a per-request predictor of the arm table; depends on ucb_pkg and ucb_bandit_arm_selector
`timescale 1ns / 1ps

module testbench;

  localparam int ARMS = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic        req_type;
    logic [3:0]  arm;
    logic [19:0] heuristic;
    logic [19:0] bound;
    logic [31:0] rand_value;
  } request_t;

  typedef struct {
    logic [3:0]  chosen_arm;
    logic        was_untried;
    logic [15:0] walk_setting;
    logic [7:0]  step_setting;
  } choice_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block inputs, all known from time zero
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = 1'b0;
  logic [3:0]  in_arm = '0;
  logic [19:0] in_heuristic = '0;
  logic [19:0] in_bound = '0;
  logic [31:0] in_rand_value = '0;
  logic        out_valid;
  logic [3:0]  out_chosen_arm;
  logic        out_was_untried;
  logic [15:0] out_walk_setting;
  logic [7:0]  out_step_setting;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [ucb_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [ucb_pkg::CFG_DW-1:0] cfg_data = '0;

  ucb_bandit_arm_selector #(.MAX_ARMS(ARMS)) dut (.*);

  // predictor copy of the registers and the arm table
  logic signed [15:0] exp_const;
  logic        exp_adjust;
  logic [4:0]  exp_num_arms;
  logic [15:0] exp_init_walks, exp_walks_bound;
  logic [7:0]  exp_init_steps, exp_steps_bound;
  bit [31:0]   arm_mean [ARMS];
  bit [31:0]   arm_pulls [ARMS];
  bit [31:0]   pulls_total;
  bit [31:0]   arm_walk [ARMS];
  bit [31:0]   arm_step [ARMS];

  request_t pending_requests[$];
  choice_t  expected_choices[$];
  int  sender_idle_pct = 14;
  int  errors = 0;
  int  stall_cycles = 0;

  function automatic int arms_in_use();
    if (exp_num_arms == 0) return 1;
    if (exp_num_arms > ARMS) return ARMS;
    return exp_num_arms;
  endfunction

  // mean + c*sqrt(2 ln total / count), or total - count in dovetail mode
  function automatic longint ucb_score(int i);
    bit [63:0] y, lg, ln_val, arg, v, r, b;
    int k;
    if (exp_const < 0) return longint'(pulls_total) - longint'(arm_pulls[i]);
    ln_val = 0;
    if (pulls_total != 0) begin
      k = 0;
      while (k < 31 && (pulls_total >> (k + 1)) != 0) k++;
      y = (k <= 30) ? (64'(pulls_total) << (30 - k)) : (64'(pulls_total) >> (k - 30));
      lg = 64'(k) << 16;
      for (int j = 0; j < 16; j++) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          lg = lg | (64'd1 << (15 - j));
        end
      end
      ln_val = (lg * 64'(ucb_pkg::LN2_Q32)) >> 32;
    end
    arg = (2 * ln_val) / 64'(arm_pulls[i]);
    v = arg << 16;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(arm_mean[i]) + longint'((64'(exp_const) * r) >> 8);
  endfunction

  function automatic void predict_choice(request_t rq);
    choice_t c;
    int use_n, nu, nt, pick;
    int untried [ARMS];
    int tied [ARMS];
    longint best, s;
    bit [31:0] w, st, hc, reward, cnt, m;
    use_n = arms_in_use();
    if (rq.req_type == 1'b0) begin
      nu = 0; nt = 0; pick = 0; best = -1;
      for (int i = 0; i < use_n; i++) begin
        if (arm_pulls[i] == 0) begin
          untried[nu] = i; nu++;
        end else begin
          s = ucb_score(i);
          if (s > best) begin
            best = s; nt = 0; tied[nt] = i; nt++;
          end else if (s == best) begin
            tied[nt] = i; nt++;
          end
        end
      end
      c.was_untried = 1'b0;
      if (nu != 0) begin
        pick = untried[rq.rand_value % nu];
        c.was_untried = 1'b1;
      end else if (nt != 0) begin
        pick = tied[rq.rand_value % nt];
      end
      if (exp_adjust) begin
        if (c.was_untried) begin
          arm_walk[pick] = 32'(exp_init_walks);
          arm_step[pick] = 32'(exp_init_steps);
        end else begin
          w = 2 * arm_walk[pick];
          st = arm_step[pick] + 1;
          arm_walk[pick] = (w < exp_walks_bound) ? w : 32'(exp_walks_bound);
          arm_step[pick] = (st < exp_steps_bound) ? st : 32'(exp_steps_bound);
        end
      end
      // virtual zero reward
      if (arm_pulls[pick] != 32'hFFFFFFFF) arm_pulls[pick]++;
      arm_mean[pick] = arm_mean[pick] - arm_mean[pick] / arm_pulls[pick];
      if (pulls_total != 32'hFFFFFFFF) pulls_total++;
      c.chosen_arm = 4'(pick);
      c.walk_setting = arm_walk[pick][15:0];
      c.step_setting = arm_step[pick][7:0];
    end else begin
      c.chosen_arm = rq.arm;
      c.was_untried = 1'b0;
      if (rq.arm >= use_n) begin
        c.walk_setting = '0;
        c.step_setting = '0;
      end else begin
        hc = 32'((rq.heuristic < rq.bound) ? rq.heuristic : rq.bound);
        reward = 32'h10000;
        cnt = arm_pulls[rq.arm] != 0 ? arm_pulls[rq.arm] : 1;
        if (rq.bound != 0) reward = 32'((64'(rq.bound - hc) << 16) / 64'(rq.bound));
        m = arm_mean[rq.arm] + reward / cnt;
        arm_mean[rq.arm] = (m > 32'h1FFFF) ? 32'h1FFFF : m;
        c.walk_setting = arm_walk[rq.arm][15:0];
        c.step_setting = arm_step[rq.arm][7:0];
      end
    end
    expected_choices = {expected_choices, c};
  endfunction

  // driver: the request in flight is folded into the predictor as it is taken
  always @(posedge clk) begin : driver
    request_t rq;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rq.req_type = in_req_type;
        rq.arm = in_arm;
        rq.heuristic = in_heuristic;
        rq.bound = in_bound;
        rq.rand_value = in_rand_value;
        predict_choice(rq);
      end
      if (!start || !busy) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          rq = pending_requests.pop_front();
          start <= 1'b1;
          in_req_type <= rq.req_type;
          in_arm <= rq.arm;
          in_heuristic <= rq.heuristic;
          in_bound <= rq.bound;
          in_rand_value <= rq.rand_value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // monitor: every strobed word is matched against the oldest prediction
  always @(posedge clk) begin : monitor
    choice_t c;
    if (rst_n && out_valid) begin
      if (expected_choices.size() == 0) begin
        $display("%0t: unexpected result, expected none actual arm %0h", $time,
                 out_chosen_arm);
        errors++;
      end else begin
        c = expected_choices.pop_front();
        check_field("chosen_arm", c.chosen_arm, out_chosen_arm);
        check_field("was_untried", c.was_untried, out_was_untried);
        check_field("walk_setting", c.walk_setting, out_walk_setting);
        check_field("step_setting", c.step_setting, out_step_setting);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic write_reg(logic [ucb_pkg::CFG_IW-1:0] idx,
                           logic [ucb_pkg::CFG_DW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ucb_pkg::CFG_UCB_CONST:   exp_const = data;
      ucb_pkg::CFG_ADJUST:      exp_adjust = data[0];
      ucb_pkg::CFG_NUM_ARMS:    exp_num_arms = data[4:0];
      ucb_pkg::CFG_INIT_WALKS:  exp_init_walks = data;
      ucb_pkg::CFG_INIT_STEPS:  exp_init_steps = data[7:0];
      ucb_pkg::CFG_WALKS_BOUND: exp_walks_bound = data;
      ucb_pkg::CFG_STEPS_BOUND: exp_steps_bound = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_phase(logic [15:0] c, logic adj, logic [4:0] n, logic [15:0] iw,
                           logic [7:0] is, logic [15:0] wb, logic [7:0] sb);
    write_reg(ucb_pkg::CFG_UCB_CONST, c);
    write_reg(ucb_pkg::CFG_ADJUST, 16'(adj));
    write_reg(ucb_pkg::CFG_NUM_ARMS, 16'(n));
    write_reg(ucb_pkg::CFG_INIT_WALKS, iw);
    write_reg(ucb_pkg::CFG_INIT_STEPS, 16'(is));
    write_reg(ucb_pkg::CFG_WALKS_BOUND, wb);
    write_reg(ucb_pkg::CFG_STEPS_BOUND, 16'(sb));
  endtask

  task automatic queue_request(logic rt, logic [3:0] a, logic [19:0] h, logic [19:0] b,
                               logic [31:0] r);
    request_t rq;
    rq.req_type = rt; rq.arm = a; rq.heuristic = h; rq.bound = b; rq.rand_value = r;
    pending_requests = {pending_requests, rq};
  endtask

  // mostly selects and updates of arms in use, some out-of-range arms and odd rewards
  task automatic queue_random(int count);
    logic [19:0] h, b;
    logic [3:0] a;
    for (int k = 0; k < count; k++) begin
      a = ($urandom_range(99) < 80) ? 4'($urandom_range(arms_in_use() - 1)) : 4'($urandom);
      case ($urandom_range(4))
        0: begin h = 20'($urandom); b = 20'($urandom); end
        1: begin h = 20'($urandom); b = '0; end
        2: begin b = 20'($urandom_range(1000)); h = b + 20'($urandom_range(5000)); end
        3: begin b = 20'($urandom_range(1, 64)); h = 20'($urandom_range(64)); end
        default: begin h = '0; b = 20'($urandom); end
      endcase
      queue_request(1'($urandom_range(1)), a, h, b, $urandom);
    end
  endtask

  // sampled away from the active edge so the driver's updates have settled
  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() > 0 || start || busy || expected_choices.size() > 0);
  endtask

  initial begin
    exp_const = 16'sd256;
    exp_adjust = 1'b0;
    exp_num_arms = 5'd16;
    exp_init_walks = 16'd100;
    exp_init_steps = 8'd1;
    exp_walks_bound = 16'd2000;
    exp_steps_bound = 8'd7;
    pulls_total = 0;
    for (int i = 0; i < ARMS; i++) begin
      arm_mean[i] = 0;
      arm_pulls[i] = 0;
      arm_walk[i] = 100;
      arm_step[i] = 1;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, extremes of every field, updates of untried and unused arms
    queue_request(1'b1, 4'd0, 20'd0, 20'd0, 32'd0);
    queue_request(1'b1, 4'd15, 20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF);
    queue_request(1'b0, 4'd0, 20'd0, 20'd0, 32'd0);
    queue_request(1'b0, 4'd15, 20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF);
    queue_request(1'b1, 4'd0, 20'd5, 20'd3, 32'd0);
    for (int i = 0; i < 6; i++) queue_request(1'b1, 4'd0, 20'd0, 20'd0, 32'd0);
    drain();
    set_phase(16'd256, 1'b1, 5'd2, 16'hFFFF, 8'hFF, 16'h0000, 8'h00);
    for (int i = 0; i < 4; i++) queue_request(1'b0, 4'd0, 20'd0, 20'd0, 32'(i));
    queue_request(1'b1, 4'd3, 20'd1, 20'd2, 32'd0);
    queue_request(1'b1, 4'd1, 20'd0, 20'hFFFFF, 32'd0);
    for (int i = 0; i < 4; i++) queue_request(1'b0, 4'd0, 20'd0, 20'd0, 32'hFFFFFFFF);
    drain();
    // dovetail with no arm in use beyond one: num_arms zero counts as one arm
    set_phase(16'h8000, 1'b1, 5'd0, 16'h0000, 8'h00, 16'hFFFF, 8'hFF);
    queue_request(1'b0, 4'd0, 20'd0, 20'd0, 32'd7);
    queue_request(1'b1, 4'd1, 20'd0, 20'd0, 32'd0);
    queue_request(1'b0, 4'd0, 20'd0, 20'd0, 32'd7);
    drain();

    // random phases, sender idling 14, then 69, then none
    sender_idle_pct = 14;
    set_phase(16'd256, 1'b1, 5'd3, 16'd5, 8'd2, 16'd40, 8'd6);
    queue_random(130); drain();
    set_phase(16'hFFFF, 1'b1, 5'd4, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    queue_random(120); drain();
    sender_idle_pct = 69;
    set_phase(16'h7FFF, 1'b0, 5'd5, 16'h5A5A, 8'hA5, 16'hA5A5, 8'h5A);
    queue_random(120); drain();
    set_phase(16'h0000, 1'b1, 5'd2, 16'd1, 8'd1, 16'd3, 8'd3);
    queue_random(110); drain();
    sender_idle_pct = 0;
    set_phase(16'h0180, 1'b1, 5'd31, 16'd300, 8'd4, 16'd1000, 8'd9);
    queue_random(60); drain();
    set_phase(16'h8000, 1'b1, 5'd16, 16'd7, 8'd3, 16'd100, 8'd12);
    queue_random(80); drain();
    set_phase(16'h0040, 1'b0, 5'd3, 16'd100, 8'd1, 16'd2000, 8'd7);
    queue_random(130); drain();

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
